### rtl/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg: shared types and constants of the multicast delivery checker
// Status codes, register indexes, queue entry layout and divider handshake.
// ----------------------------------------------------------------------------
package mdc_pkg;

  localparam int MAX_BLOCK_CELLS = 64;
  localparam int QUEUE_DEPTH     = 4;
  localparam int DIV_DVD_W       = 16;
  localparam int DIV_DSR_W       = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [6:0]  POS_MAX = 7'd127;
  localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DECODE    = 3'd1;
  localparam logic [2:0] ST_STAGE     = 3'd2;
  localparam logic [2:0] ST_DEST      = 3'd3;
  localparam logic [2:0] ST_BLOCKPOS  = 3'd4;
  localparam logic [2:0] ST_MASK      = 3'd5;
  localparam logic [2:0] ST_UNCHECKED = 3'd6;
  localparam int         NUM_STATUS   = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_NODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_CORE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MESH_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = 2'd3;

  // packet kinds
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_KEYED = 2'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  hops;
    logic        decode_ok;
    logic [7:0]  version;
    logic [7:0]  stage;
    logic [15:0] dest_node;
    logic [7:0]  dest_core;
    logic [15:0] block_shape;
    logic [15:0] block_number;
  } hdr_t;

  typedef struct packed {
    logic        func;
    logic        last;
    hdr_t        hdr;
    logic [31:0] mask;
  } qent_t;

  typedef struct packed {
    logic [15:0] self_node;
    logic [7:0]  self_core;
    logic [7:0]  mesh_width;
    logic        check_enable;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVD_W-1:0] quotient;
    logic [DIV_DSR_W-1:0] remainder;
  } div_rsp_t;

endpackage

### rtl/mdc_if.sv
// ----------------------------------------------------------------------------
// mdc_if: input and result channel interfaces
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mdc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [1:0]  kind;
  logic [7:0]  hop_count;
  logic        decode_ok;
  logic [7:0]  key_version;
  logic [7:0]  stage;
  logic [15:0] dest_node;
  logic [7:0]  dest_core;
  logic [15:0] block_shape;
  logic [15:0] block_number;
  logic [31:0] mask_word;
  logic        last;

  modport source (
    output valid, func, kind, hop_count, decode_ok, key_version, stage,
           dest_node, dest_core, block_shape, block_number, mask_word, last,
    input  ready
  );
  modport sink (
    input  valid, func, kind, hop_count, decode_ok, key_version, stage,
           dest_node, dest_core, block_shape, block_number, mask_word, last,
    output ready
  );
endinterface

interface mdc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  cell_index;
  logic [1:0]  kind_seen;
  logic [31:0] kind_packet_count;
  logic [47:0] kind_hops_sum;
  logic [7:0]  kind_hops_max;

  modport source (
    output valid, status, cell_index, kind_seen, kind_packet_count,
           kind_hops_sum, kind_hops_max,
    input  ready
  );
  modport sink (
    input  valid, status, cell_index, kind_seen, kind_packet_count,
           kind_hops_sum, kind_hops_max,
    output ready
  );
endinterface

### rtl/mdc_front.sv
// ----------------------------------------------------------------------------
// mdc_front: input front end
// Accepts beats, sorts them into header or mask entries, and queues them.
// ----------------------------------------------------------------------------
module mdc_front (
  input  logic          clk,
  input  logic          rst_n,
  mdc_in_if.sink        in_bus,
  output logic          q_valid,
  output mdc_pkg::qent_t q_head,
  input  logic          q_pop
);

  localparam int PTR_W = $clog2(mdc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(mdc_pkg::QUEUE_DEPTH + 1);

  mdc_pkg::qent_t   mem_r [mdc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  mdc_pkg::qent_t   ent;
  logic             push;
  logic             pop;

  assign in_bus.ready = (cnt_r != CNT_W'(mdc_pkg::QUEUE_DEPTH));
  assign push         = in_bus.valid && in_bus.ready;
  assign pop          = q_pop && q_valid;
  assign q_valid      = (cnt_r != '0);
  assign q_head       = mem_r[rd_ptr_r];

  always_comb begin
    ent                  = '0;
    ent.func             = in_bus.func;
    ent.last             = in_bus.last;
    ent.hdr.kind         = in_bus.kind;
    ent.hdr.hops         = in_bus.hop_count;
    ent.hdr.decode_ok    = in_bus.decode_ok;
    ent.hdr.version      = in_bus.key_version;
    ent.hdr.stage        = in_bus.stage;
    ent.hdr.dest_node    = in_bus.dest_node;
    ent.hdr.dest_core    = in_bus.dest_core;
    ent.hdr.block_shape  = in_bus.block_shape;
    ent.hdr.block_number = in_bus.block_number;
    ent.mask             = in_bus.mask_word;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(mdc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(mdc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= ent;
    end
  end

endmodule

### rtl/mdc_div.sv
// ----------------------------------------------------------------------------
// mdc_div: serial restoring divider
// One quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module mdc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mdc_pkg::div_req_t req,
  output mdc_pkg::div_rsp_t rsp
);

  localparam int DVD_W = mdc_pkg::DIV_DVD_W;
  localparam int DSR_W = mdc_pkg::DIV_DSR_W;
  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DSR_W:0]   rem_r;
  logic [DSR_W-1:0] dsr_r;

  logic [DSR_W:0]   shifted;
  logic             ge;
  logic [DSR_W:0]   rem_nxt;
  logic [DVD_W-1:0] quo_nxt;

  assign shifted = {rem_r[DSR_W-1:0], quo_r[DVD_W-1]};
  assign ge      = (shifted >= {1'b0, dsr_r});
  assign rem_nxt = ge ? (shifted - {1'b0, dsr_r}) : shifted;
  assign quo_nxt = {quo_r[DVD_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r[DSR_W-1:0];

endmodule

### rtl/mdc_back.sv
// ----------------------------------------------------------------------------
// mdc_back: packet execution back end
// Holds the header, works out the cell position, captures the mask word,
// keeps the saturating counters and drives the result register.
// ----------------------------------------------------------------------------
module mdc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mdc_pkg::cfg_t     cfg,
  input  logic              cfg_touch,
  input  logic              q_valid,
  input  mdc_pkg::qent_t    q_head,
  output logic              q_pop,
  output mdc_pkg::div_req_t div_req,
  input  mdc_pkg::div_rsp_t div_rsp,
  mdc_out_if.source         out_bus
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV1 = 7'b0000010,
    S_DIV2 = 7'b0000100,
    S_DIV3 = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_CHK  = 7'b0100000,
    S_IDX  = 7'b1000000
  } bstate_t;

  bstate_t        state_r, state_nxt;
  mdc_pkg::hdr_t  hdr_r;
  logic [6:0]     pos_r, pos_nxt;
  logic [31:0]    chosen_r, chosen_nxt;
  logic           pos_valid_r, pos_valid_nxt;
  logic           fin_pend_r, fin_pend_nxt;

  // position datapath
  logic [7:0]     sx_r, blkw_r, br_r;
  logic [15:0]    sy_r, bq_r, x0_r, cells_r, lx_r, ly_r;
  logic [23:0]    y0_r;
  logic           ok_lo_r, ok_in_r;
  logic [2:0]     pos_status_r;
  logic [7:0]     idx_r;

  // counters
  logic [31:0]    pkt_cnt_r [2];
  logic [47:0]    hop_sum_r [2];
  logic [7:0]     hop_max_r [2];
  logic [31:0]    verdict_r [mdc_pkg::NUM_STATUS];

  // result register
  logic           out_valid_r, out_valid_nxt;
  logic [2:0]     out_status_r;
  logic [5:0]     out_cell_r;
  logic [1:0]     out_kind_r;
  logic [31:0]    out_cnt_r;
  logic [47:0]    out_sum_r;
  logic [7:0]     out_max_r;

  logic           out_free;
  logic           hdr_load;
  logic           fin_now;
  logic           capture;
  logic [31:0]    use_chosen;

  logic [7:0]     bw, bh;
  logic           fail_dec, fail_stg, fail_dst;
  logic [15:0]    x0_prod, cells_prod, i_prod, i_val;
  logic [23:0]    y0_prod;
  logic           ok_lo;
  logic [15:0]    lx, ly;
  logic [23:0]    ly_wide;
  logic [2:0]     pos_status;

  assign bw = hdr_r.block_shape[15:8];
  assign bh = hdr_r.block_shape[7:0];

  assign fail_dec = !hdr_r.decode_ok || (hdr_r.version != 8'd1 && hdr_r.version != 8'd2);
  assign fail_stg = (hdr_r.stage != 8'd1);
  assign fail_dst = (hdr_r.dest_node != cfg.self_node) || (hdr_r.dest_core != cfg.self_core);

  assign x0_prod    = br_r * bw;
  assign y0_prod    = bq_r * bh;
  assign cells_prod = bw * bh;

  assign ok_lo   = ({8'b0, sx_r} >= x0_r) && ({8'b0, sy_r} >= y0_r);
  assign lx      = {8'b0, sx_r} - x0_r;
  assign ly_wide = {8'b0, sy_r} - y0_r;
  assign ly      = ly_wide[15:0];

  assign i_prod = ly_r[7:0] * bw;
  assign i_val  = i_prod + {8'b0, lx_r[7:0]};

  // checks in order; the first failure wins
  always_comb begin
    if (fail_dec) begin
      pos_status = mdc_pkg::ST_DECODE;
    end else if (fail_stg) begin
      pos_status = mdc_pkg::ST_STAGE;
    end else if (fail_dst) begin
      pos_status = mdc_pkg::ST_DEST;
    end else if (cfg.mesh_width == 8'd0 || bw == 8'd0 || bh == 8'd0 ||
                 cells_r > 16'(mdc_pkg::MAX_BLOCK_CELLS) || blkw_r == 8'd0 ||
                 !ok_lo_r || !ok_in_r || i_val >= cells_r ||
                 i_val >= 16'(mdc_pkg::MAX_BLOCK_CELLS)) begin
      pos_status = mdc_pkg::ST_BLOCKPOS;
    end else begin
      pos_status = mdc_pkg::ST_OK;
    end
  end

  assign out_free = !out_valid_r || out_bus.ready;
  assign capture  = (pos_status_r == mdc_pkg::ST_OK) && (pos_r != mdc_pkg::POS_MAX) &&
                    ({1'b0, pos_r} == idx_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    chosen_nxt    = chosen_r;
    pos_valid_nxt = pos_valid_r;
    fin_pend_nxt  = fin_pend_r;
    hdr_load      = 1'b0;
    q_pop         = 1'b0;
    fin_now       = 1'b0;
    use_chosen    = chosen_r;
    div_req       = '0;
    out_valid_nxt = out_valid_r && !out_bus.ready;

    case (state_r)
      S_IDLE: begin
        if (fin_pend_r) begin
          // header that also ended its packet
          if (!pos_valid_r) begin
            div_req.start    = 1'b1;
            div_req.dividend = cfg.self_node;
            div_req.divisor  = cfg.mesh_width;
            state_nxt        = S_DIV1;
          end else if (out_free) begin
            fin_now      = 1'b1;
            fin_pend_nxt = 1'b0;
          end
        end else if (q_valid && !q_head.func) begin
          q_pop         = 1'b1;
          hdr_load      = 1'b1;
          pos_nxt       = '0;
          chosen_nxt    = '0;
          pos_valid_nxt = 1'b0;
          fin_pend_nxt  = q_head.last;
        end else if (q_valid) begin
          if (!pos_valid_r) begin
            div_req.start    = 1'b1;
            div_req.dividend = cfg.self_node;
            div_req.divisor  = cfg.mesh_width;
            state_nxt        = S_DIV1;
          end else if (!q_head.last || out_free) begin
            q_pop = 1'b1;
            if (capture) begin
              use_chosen = q_head.mask;
            end
            chosen_nxt = use_chosen;
            if (pos_r != mdc_pkg::POS_MAX) begin
              pos_nxt = pos_r + 7'd1;
            end
            fin_now = q_head.last;
          end
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {8'b0, cfg.mesh_width};
          div_req.divisor  = bw;
          state_nxt        = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = hdr_r.block_number;
          div_req.divisor  = div_rsp.quotient[7:0];
          state_nxt        = S_DIV3;
        end
      end
      S_DIV3: begin
        if (div_rsp.done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_IDX;
      end
      S_IDX: begin
        pos_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin_now) begin
      pos_nxt       = '0;
      chosen_nxt    = '0;
      out_valid_nxt = 1'b1;
    end
    // new settings invalidate the cached position
    if (cfg_touch) begin
      pos_valid_nxt = 1'b0;
    end
  end

  // finish datapath
  logic        counted;
  logic        kix;
  logic [31:0] cnt_new;
  logic [48:0] sum_wide;
  logic [47:0] sum_new;
  logic [7:0]  max_new;
  logic [2:0]  fin_status;
  logic [5:0]  fin_cell;

  assign counted  = (hdr_r.kind == mdc_pkg::KIND_PLAIN) || (hdr_r.kind == mdc_pkg::KIND_KEYED);
  assign kix      = hdr_r.kind[0];
  assign cnt_new  = (pkt_cnt_r[kix] == mdc_pkg::CNT_MAX) ? pkt_cnt_r[kix] : pkt_cnt_r[kix] + 32'd1;
  assign sum_wide = {1'b0, hop_sum_r[kix]} + {41'b0, hdr_r.hops};
  assign sum_new  = sum_wide[48] ? mdc_pkg::SUM_MAX : sum_wide[47:0];
  assign max_new  = (hdr_r.hops > hop_max_r[kix]) ? hdr_r.hops : hop_max_r[kix];

  always_comb begin
    fin_status = mdc_pkg::ST_UNCHECKED;
    fin_cell   = '0;
    if (hdr_r.kind == mdc_pkg::KIND_KEYED && cfg.check_enable) begin
      fin_status = pos_status_r;
      if (pos_status_r == mdc_pkg::ST_OK) begin
        fin_cell = idx_r[5:0];
        if (hdr_r.dest_core >= 8'd32 || !use_chosen[hdr_r.dest_core[4:0]]) begin
          fin_status = mdc_pkg::ST_MASK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      chosen_r    <= '0;
      pos_valid_r <= 1'b0;
      fin_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        pkt_cnt_r[k] <= '0;
        hop_sum_r[k] <= '0;
        hop_max_r[k] <= '0;
      end
      for (int k = 0; k < mdc_pkg::NUM_STATUS; k++) begin
        verdict_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      chosen_r    <= chosen_nxt;
      pos_valid_r <= pos_valid_nxt;
      fin_pend_r  <= fin_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (fin_now && counted) begin
        pkt_cnt_r[kix] <= cnt_new;
        hop_sum_r[kix] <= sum_new;
        hop_max_r[kix] <= max_new;
      end
      if (fin_now && hdr_r.kind == mdc_pkg::KIND_KEYED &&
          verdict_r[fin_status] != mdc_pkg::CNT_MAX) begin
        verdict_r[fin_status] <= verdict_r[fin_status] + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_load) begin
      hdr_r <= q_head.hdr;
    end
    if (state_r == S_DIV1 && div_rsp.done) begin
      sx_r <= div_rsp.remainder;
      sy_r <= div_rsp.quotient;
    end
    if (state_r == S_DIV2 && div_rsp.done) begin
      blkw_r <= div_rsp.quotient[7:0];
    end
    if (state_r == S_DIV3 && div_rsp.done) begin
      bq_r <= div_rsp.quotient;
      br_r <= div_rsp.remainder;
    end
    if (state_r == S_MUL) begin
      x0_r    <= x0_prod;
      y0_r    <= y0_prod;
      cells_r <= cells_prod;
    end
    if (state_r == S_CHK) begin
      lx_r    <= lx;
      ly_r    <= ly;
      ok_lo_r <= ok_lo;
      ok_in_r <= ok_lo && (lx < {8'b0, bw}) && (ly < {8'b0, bh});
    end
    if (state_r == S_IDX) begin
      pos_status_r <= pos_status;
      idx_r        <= i_val[7:0];
    end
    if (fin_now) begin
      out_status_r <= fin_status;
      out_cell_r   <= fin_cell;
      out_kind_r   <= hdr_r.kind;
      out_cnt_r    <= counted ? cnt_new : 32'd0;
      out_sum_r    <= counted ? sum_new : 48'd0;
      out_max_r    <= counted ? max_new : 8'd0;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.status            = out_status_r;
  assign out_bus.cell_index        = out_cell_r;
  assign out_bus.kind_seen         = out_kind_r;
  assign out_bus.kind_packet_count = out_cnt_r;
  assign out_bus.kind_hops_sum     = out_sum_r;
  assign out_bus.kind_hops_max     = out_max_r;

endmodule

### rtl/multicast_delivery_checker_core.sv
// ----------------------------------------------------------------------------
// multicast_delivery_checker_core: receive-side multicast delivery checker
// Counts packets and hops per kind and checks keyed packets against this node.
// ----------------------------------------------------------------------------
// Path: an accepted beat is queued; a packet-ending beat goes on to the result
//   register when the cell position is already known. Headers and mask words
//   retire 1 per cycle, a packet end only if the result register is free;
//   after a header or register write the first mask word (or header-only
//   packet) waits for three 16-step serial divisions, multiply and compare.
// Reset: synchronous, active low; counters clear, registers take defaults
//   (check_enable = 1), queue empties. No clearing pass.
module multicast_delivery_checker_core (
  input  logic                             clk,
  input  logic                             rst_n,
  mdc_in_if.sink                           in_bus,
  mdc_out_if.source                        out_bus,
  input  logic                             cfg_we,
  input  logic [mdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mdc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // configuration registers
  mdc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r              <= '0;
      cfg_r.check_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        mdc_pkg::CFG_SELF_NODE:    cfg_r.self_node    <= cfg_data;
        mdc_pkg::CFG_SELF_CORE:    cfg_r.self_core    <= cfg_data[7:0];
        mdc_pkg::CFG_MESH_WIDTH:   cfg_r.mesh_width   <= cfg_data[7:0];
        mdc_pkg::CFG_CHECK_ENABLE: cfg_r.check_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // front: accept and queue beats
  logic              q_valid;
  mdc_pkg::qent_t    q_head;
  logic              q_pop;

  mdc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  // shared divider for the position math
  mdc_pkg::div_req_t div_req;
  mdc_pkg::div_rsp_t div_rsp;

  mdc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // back: position, mask capture, counters, result register
  mdc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cfg_touch (cfg_we),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_bus   (out_bus)
  );

endmodule

### rtl/mdc_checker.sv
// ----------------------------------------------------------------------------
// mdc_checker: result port assertions
// Watches result beats of the checker core.
// ----------------------------------------------------------------------------
module mdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [5:0]  cell_index,
  input logic [1:0]  kind_seen,
  input logic [31:0] kind_packet_count,
  input logic [47:0] kind_hops_sum,
  input logic [7:0]  kind_hops_max
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(kind_packet_count))
    else $error("result beat dropped or changed while stalled");

  a_other: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind_seen[1] |-> status == mdc_pkg::ST_UNCHECKED &&
      kind_packet_count == 32'd0 && kind_hops_sum == 48'd0 && kind_hops_max == 8'd0)
    else $error("other-kind beat carries counters or a verdict");

  a_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind_seen == mdc_pkg::KIND_PLAIN |->
      status == mdc_pkg::ST_UNCHECKED && kind_packet_count != 32'd0 && cell_index == 6'd0)
    else $error("plain beat checked or not counted");

  a_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != mdc_pkg::ST_OK && status != mdc_pkg::ST_MASK |->
      cell_index == 6'd0)
    else $error("cell index set without a passed position check");

endmodule

bind multicast_delivery_checker_core mdc_checker u_mdc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .status            (out_bus.status),
  .cell_index        (out_bus.cell_index),
  .kind_seen         (out_bus.kind_seen),
  .kind_packet_count (out_bus.kind_packet_count),
  .kind_hops_sum     (out_bus.kind_hops_sum),
  .kind_hops_max     (out_bus.kind_hops_max)
);
